// ===== design/cdll_pkg.sv =====
// Shared types, codes and layout constants for the cursor linked list unit.
package cdll_pkg;

   localparam int DEF_CAPACITY  = 256;
   localparam int DEF_ITEM_BITS = 32;

   localparam int CMD_W        = 4;
   localparam int ITEM_FIELD_W = 32;
   localparam int STATUS_W     = 3;

   // response tdata layout, lowest bit up
   localparam int RV_LSB   = 0;
   localparam int STS_LSB  = 32;
   localparam int AF_BIT   = 35;
   localparam int AL_BIT   = 36;
   localparam int EMP_BIT  = 37;
   localparam int CNT_LSB  = 38;

   localparam logic [CMD_W-1:0] CMD_FIRST      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LAST       = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FORWARD    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_BACKWARD   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd4;
   localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_GET_BEFORE = 4'd6;
   localparam logic [CMD_W-1:0] CMD_GET_AFTER  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SET_BEFORE = 4'd8;
   localparam logic [CMD_W-1:0] CMD_SET_AFTER  = 4'd9;
   localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 4'd10;
   localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 4'd11;

   localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FIRST = 3'd2;
   localparam logic [STATUS_W-1:0] STS_LAST  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FULL  = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_INS_LINK,
      S_DEL_LINK,
      S_POST
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CUR_FIRST,
      OP_CUR_LAST,
      OP_CUR_NEXT,
      OP_CUR_PREV,
      OP_FILL_CUR,
      OP_INS_NEW,
      OP_INS_LINK,
      OP_GET,
      OP_SET,
      OP_DEL_EMPTY,
      OP_DEL_READ,
      OP_DEL_LINK
   } op_type;

   typedef struct packed {
      logic                accept;
      op_type              op;
      logic                st_load;
      logic [STATUS_W-1:0] st_code;
      logic                rsp_load;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             list_empty;
      logic             at_first;
      logic             at_last;
      logic             pool_empty;
      logic             single;
      logic             rsp_free;
   } stat_type;

endpackage

// ===== design/cdll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cdll_ctrl.sv =====
// Command sequencer for the cursor linked list unit.
module cdll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  cdll_pkg::stat_type stat,
   output cdll_pkg::ctl_type  ctl
);
   import cdll_pkg::*;

   state_type           state_ff, state_in;
   op_type              eval_op;
   logic [STATUS_W-1:0] eval_code;
   logic                prev_side;

   assign prev_side = ~stat.cmd[0];

   // decide what the captured request does, from the state before it
   always_comb begin
      eval_op   = OP_NONE;
      eval_code = STS_OK;
      unique case (stat.cmd)
         CMD_FIRST: eval_op = OP_CUR_FIRST;
         CMD_LAST:  eval_op = OP_CUR_LAST;
         CMD_FORWARD: begin
            if (stat.at_last) eval_code = STS_LAST;
            else              eval_op   = OP_CUR_NEXT;
         end
         CMD_BACKWARD: begin
            if (stat.at_first) eval_code = STS_FIRST;
            else               eval_op   = OP_CUR_PREV;
         end
         CMD_INS_BEFORE, CMD_INS_AFTER: begin
            priority if (stat.list_empty) eval_op   = OP_FILL_CUR;
            else if (stat.pool_empty)     eval_code = STS_FULL;
            else                          eval_op   = OP_INS_NEW;
         end
         CMD_GET_BEFORE, CMD_GET_AFTER, CMD_SET_BEFORE, CMD_SET_AFTER: begin
            priority if (stat.list_empty)          eval_code = STS_EMPTY;
            else if (prev_side && stat.at_first)   eval_code = STS_FIRST;
            else if (!prev_side && stat.at_last)   eval_code = STS_LAST;
            else if (stat.cmd == CMD_GET_BEFORE || stat.cmd == CMD_GET_AFTER)
               eval_op = OP_GET;
            else
               eval_op = OP_SET;
         end
         CMD_DEL_BEFORE, CMD_DEL_AFTER: begin
            priority if (stat.list_empty)          eval_code = STS_EMPTY;
            else if (stat.single)                  eval_op   = OP_DEL_EMPTY;
            else if (prev_side && stat.at_first)   eval_code = STS_FIRST;
            else if (!prev_side && stat.at_last)   eval_code = STS_LAST;
            else                                   eval_op   = OP_DEL_READ;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (eval_op == OP_INS_NEW)  state_in = S_INS_LINK;
            else if (eval_op == OP_DEL_READ)     state_in = S_DEL_LINK;
            else                                 state_in = S_POST;
         end
         S_INS_LINK: state_in = S_POST;
         S_DEL_LINK: state_in = S_POST;
         S_POST: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      ctl.accept   = 1'b0;
      ctl.op       = OP_NONE;
      ctl.st_load  = 1'b0;
      ctl.st_code  = STS_OK;
      ctl.rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // hold off requests while reset is applied
            req_tready = !reset;
            ctl.accept = req_tvalid && !reset;
         end
         S_EVAL: begin
            ctl.op      = eval_op;
            ctl.st_load = 1'b1;
            ctl.st_code = eval_code;
         end
         S_INS_LINK: ctl.op = OP_INS_LINK;
         S_DEL_LINK: ctl.op = OP_DEL_LINK;
         S_POST:     ctl.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/cdll_dp.sv =====
// List state, link and item memories, free-index stack and response register.
module cdll_dp #(
   parameter int CAPACITY  = cdll_pkg::DEF_CAPACITY,
   parameter int ITEM_BITS = cdll_pkg::DEF_ITEM_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cdll_pkg::ctl_type                     ctl,
   output cdll_pkg::stat_type                    stat,
   input  logic [cdll_pkg::CMD_W-1:0]            req_cmd,
   input  logic [cdll_pkg::ITEM_FIELD_W-1:0]     req_item_value,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [cdll_pkg::ITEM_FIELD_W-1:0]     rsp_read_value,
   output logic [cdll_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_at_first,
   output logic                                  rsp_at_last,
   output logic                                  rsp_is_empty,
   output logic [$clog2(CAPACITY+1)-1:0]         rsp_cell_count
);
   import cdll_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LNK_W = IDX_W + 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [LNK_W-1:0] NIL = LNK_W'(CAPACITY);

   // control state
   logic [IDX_W-1:0] cur_ff, cur_in, first_ff, first_in, last_ff, last_in;
   logic [IDX_W-1:0] free_top_ff, free_top_in, low_mark_ff, low_mark_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             empty_ff, empty_in;
   logic             prev0_fresh_ff, prev0_fresh_in, next0_fresh_ff, next0_fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CMD_W-1:0]     cmd_ff;
   logic [ITEM_BITS-1:0] val_ff;
   logic [IDX_W-1:0]     new_ff, new_in;
   logic [LNK_W-1:0]     nbr_ff, nbr_in;
   logic [STATUS_W-1:0]  st_ff;
   logic                 rv_sel_ff;
   logic                 prev_ovr_ff, prev_ovr_in, next_ovr_ff, next_ovr_in, free_ovr_ff;
   logic [ITEM_FIELD_W-1:0] rsp_rv_ff;
   logic [STATUS_W-1:0]  rsp_st_ff;
   logic                 rsp_af_ff, rsp_al_ff, rsp_emp_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;

   // memory ports
   logic                 prev_we, next_we, item_we, free_we;
   logic [IDX_W-1:0]     prev_waddr, next_waddr, item_waddr, free_waddr;
   logic [LNK_W-1:0]     prev_wdata, next_wdata;
   logic [ITEM_BITS-1:0] item_wdata;
   logic [IDX_W-1:0]     free_wdata;
   logic [IDX_W-1:0]     prev_raddr, next_raddr, item_raddr, free_raddr;
   logic [LNK_W-1:0]     prev_rdata, next_rdata;
   logic [ITEM_BITS-1:0] item_rdata;
   logic [IDX_W-1:0]     free_rdata;

   logic             prev_side;
   logic [LNK_W-1:0] p_lnk, nx_lnk, nbr_sel, cur_lnk;
   logic [IDX_W-1:0] free_pos, new_idx;

   assign prev_side = ~cmd_ff[0];
   // cell 0 links read as null until first written
   assign p_lnk    = prev_ovr_ff ? NIL : prev_rdata;
   assign nx_lnk   = next_ovr_ff ? NIL : next_rdata;
   assign nbr_sel  = prev_side ? p_lnk : nx_lnk;
   assign cur_lnk  = {1'b0, cur_ff};
   assign free_pos = free_top_ff - IDX_W'(1);
   // a stack slot below the low mark was never pushed: it holds its reset index
   assign new_idx  = free_ovr_ff ? free_top_ff : free_rdata;
   assign free_raddr = free_pos;

   always_comb begin
      cur_in      = cur_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      free_top_in = free_top_ff;
      low_mark_in = low_mark_ff;
      count_in    = count_ff;
      empty_in    = empty_ff;
      new_in      = new_ff;
      nbr_in      = nbr_ff;
      prev_we     = 1'b0;
      prev_waddr  = cur_ff;
      prev_wdata  = cur_lnk;
      next_we     = 1'b0;
      next_waddr  = cur_ff;
      next_wdata  = cur_lnk;
      item_we     = 1'b0;
      item_waddr  = cur_ff;
      item_wdata  = val_ff;
      free_we     = 1'b0;
      free_waddr  = free_top_ff;
      free_wdata  = nbr_ff[IDX_W-1:0];
      prev_raddr  = cur_ff;
      next_raddr  = cur_ff;
      item_raddr  = nbr_sel[IDX_W-1:0];
      unique case (ctl.op)
         OP_NONE: ;
         OP_CUR_FIRST: cur_in = first_ff;
         OP_CUR_LAST:  cur_in = last_ff;
         OP_CUR_NEXT:  cur_in = nx_lnk[IDX_W-1:0];
         OP_CUR_PREV:  cur_in = p_lnk[IDX_W-1:0];
         OP_FILL_CUR: begin
            item_we  = 1'b1;
            empty_in = 1'b0;
         end
         OP_INS_NEW: begin
            item_we     = 1'b1;
            item_waddr  = new_idx;
            prev_we     = 1'b1;
            prev_waddr  = new_idx;
            prev_wdata  = prev_side ? p_lnk : cur_lnk;
            next_we     = 1'b1;
            next_waddr  = new_idx;
            next_wdata  = prev_side ? cur_lnk : nx_lnk;
            new_in      = new_idx;
            nbr_in      = nbr_sel;
            free_top_in = free_pos;
            if (free_pos < low_mark_ff) low_mark_in = free_pos;
            count_in    = count_ff + CNT_W'(1);
         end
         OP_INS_LINK: begin
            if (prev_side) begin
               prev_we    = 1'b1;
               prev_wdata = {1'b0, new_ff};
               if (nbr_ff == NIL) begin
                  first_in = new_ff;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = nbr_ff[IDX_W-1:0];
                  next_wdata = {1'b0, new_ff};
               end
            end else begin
               next_we    = 1'b1;
               next_wdata = {1'b0, new_ff};
               if (nbr_ff == NIL) begin
                  last_in = new_ff;
               end else begin
                  prev_we    = 1'b1;
                  prev_waddr = nbr_ff[IDX_W-1:0];
                  prev_wdata = {1'b0, new_ff};
               end
            end
         end
         OP_GET: ;
         OP_SET: begin
            item_we    = 1'b1;
            item_waddr = nbr_sel[IDX_W-1:0];
         end
         OP_DEL_EMPTY: empty_in = 1'b1;
         OP_DEL_READ: begin
            // fetch the neighbour's outer link
            nbr_in     = nbr_sel;
            prev_raddr = nbr_sel[IDX_W-1:0];
            next_raddr = nbr_sel[IDX_W-1:0];
         end
         OP_DEL_LINK: begin
            if (prev_side) begin
               prev_we    = 1'b1;
               prev_wdata = nbr_sel;
               if (nbr_sel == NIL) begin
                  first_in = cur_ff;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = nbr_sel[IDX_W-1:0];
               end
            end else begin
               next_we    = 1'b1;
               next_wdata = nbr_sel;
               if (nbr_sel == NIL) begin
                  last_in = cur_ff;
               end else begin
                  prev_we    = 1'b1;
                  prev_waddr = nbr_sel[IDX_W-1:0];
               end
            end
            free_we     = 1'b1;
            free_top_in = free_top_ff + IDX_W'(1);
            count_in    = count_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      prev0_fresh_in = prev0_fresh_ff && !(prev_we && prev_waddr == '0);
      next0_fresh_in = next0_fresh_ff && !(next_we && next_waddr == '0);
      prev_ovr_in    = prev0_fresh_ff && (prev_raddr == '0);
      next_ovr_in    = next0_fresh_ff && (next_raddr == '0);
      rsp_valid_in   = ctl.rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         first_ff       <= '0;
         last_ff        <= '0;
         free_top_ff    <= IDX_W'(CAPACITY - 1);
         low_mark_ff    <= IDX_W'(CAPACITY - 1);
         count_ff       <= CNT_W'(1);
         empty_ff       <= 1'b1;
         prev0_fresh_ff <= 1'b1;
         next0_fresh_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_ff         <= cur_in;
         first_ff       <= first_in;
         last_ff        <= last_in;
         free_top_ff    <= free_top_in;
         low_mark_ff    <= low_mark_in;
         count_ff       <= count_in;
         empty_ff       <= empty_in;
         prev0_fresh_ff <= prev0_fresh_in;
         next0_fresh_ff <= next0_fresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= req_cmd;
         val_ff <= ITEM_BITS'(req_item_value);
      end
      if (ctl.st_load) begin
         st_ff     <= ctl.st_code;
         rv_sel_ff <= (ctl.op == OP_GET);
      end
      new_ff      <= new_in;
      nbr_ff      <= nbr_in;
      prev_ovr_ff <= prev_ovr_in;
      next_ovr_ff <= next_ovr_in;
      free_ovr_ff <= (free_top_ff == low_mark_ff);
      if (ctl.rsp_load) begin
         rsp_rv_ff  <= rv_sel_ff ? ITEM_FIELD_W'(item_rdata) : '0;
         rsp_st_ff  <= st_ff;
         rsp_af_ff  <= (cur_ff == first_ff);
         rsp_al_ff  <= (cur_ff == last_ff);
         rsp_emp_ff <= empty_ff;
         rsp_cnt_ff <= count_ff;
      end
   end

   cdll_ram #(.WIDTH(LNK_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (prev_raddr),
      .rd_data (prev_rdata)
   );

   cdll_ram #(.WIDTH(LNK_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (next_raddr),
      .rd_data (next_rdata)
   );

   cdll_ram #(.WIDTH(ITEM_BITS), .DEPTH(CAPACITY)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_waddr),
      .wr_data (item_wdata),
      .rd_addr (item_raddr),
      .rd_data (item_rdata)
   );

   cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (free_wdata),
      .rd_addr (free_raddr),
      .rd_data (free_rdata)
   );

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.list_empty = empty_ff;
      stat.at_first   = (cur_ff == first_ff);
      stat.at_last    = (cur_ff == last_ff);
      stat.pool_empty = (free_top_ff == '0);
      stat.single     = (count_ff == CNT_W'(1));
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_read_value = rsp_rv_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_at_first   = rsp_af_ff;
   assign rsp_at_last    = rsp_al_ff;
   assign rsp_is_empty   = rsp_emp_ff;
   assign rsp_cell_count = rsp_cnt_ff;

endmodule

// ===== design/cursor_doubly_linked_list_unit.sv =====
// Doubly linked list with a cursor over a fixed pool of CAPACITY cells. Each request
// carries a command in req_tuser and an item value in req_tdata and produces exactly one
// response: read data, a status code, the at-first/at-last flags, the empty flag and the
// cell count after the command. The list starts as one empty cell holding the cursor.
// Requests are taken one at a time: cursor moves, gets, sets, fills of an empty list and
// rejected commands pass through the evaluate and post states; inserts and deletes that
// relink cells add a link state between them, holding the second write to the link
// memories for an insert, or the relinking that waits on the dependent read of the
// neighbor's outer link for a delete. A finished response waits in an output register,
// so a new request is taken while it is held. No clearing pass after reset: the links of
// the first cell and untouched free-stack slots are tracked by flags and a low mark.
module cursor_doubly_linked_list_unit #(
   parameter int CAPACITY  = cdll_pkg::DEF_CAPACITY,
   parameter int ITEM_BITS = cdll_pkg::DEF_ITEM_BITS,
   localparam int CNT_W       = $clog2(CAPACITY + 1),
   localparam int RSP_BITS    = cdll_pkg::CNT_LSB + CNT_W,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // item_value
   input  logic [3:0]              req_tuser,   // cmd
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // read_value, status, at_first, at_last, is_empty, cell_count, zero pad
   output logic [RSP_TDATA_W-1:0]  rsp_tdata
);
   import cdll_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   logic [ITEM_FIELD_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_at_first, rsp_at_last, rsp_is_empty;
   logic [CNT_W-1:0]        rsp_cell_count;

   cdll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   cdll_dp #(.CAPACITY(CAPACITY), .ITEM_BITS(ITEM_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_tuser),
      .req_item_value (req_tdata),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_at_first   (rsp_at_first),
      .rsp_at_last    (rsp_at_last),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_cell_count (rsp_cell_count)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_cell_count, rsp_is_empty, rsp_at_last,
                                    rsp_at_first, rsp_status, rsp_read_value});

endmodule

// ===== design/cdll_checker.sv =====
// Port-level checks for the cursor linked list unit, bound to the top level.
module cdll_checker #(
   parameter int CAPACITY = cdll_pkg::DEF_CAPACITY,
   localparam int CNT_W       = $clog2(CAPACITY + 1),
   localparam int RSP_TDATA_W = ((cdll_pkg::CNT_LSB + CNT_W + 7) / 8) * 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);
   import cdll_pkg::*;

   logic [ITEM_FIELD_W-1:0] read_value;
   logic [STATUS_W-1:0]     status;
   logic                    at_first, at_last, is_empty;
   logic [CNT_W-1:0]        cell_count;

   assign read_value = rsp_tdata[RV_LSB +: ITEM_FIELD_W];
   assign status     = rsp_tdata[STS_LSB +: STATUS_W];
   assign at_first   = rsp_tdata[AF_BIT];
   assign at_last    = rsp_tdata[AL_BIT];
   assign is_empty   = rsp_tdata[EMP_BIT];
   assign cell_count = rsp_tdata[CNT_LSB +: CNT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_empty |-> cell_count == CNT_W'(1))
      else $error("empty list reports more than one cell");

   a_single_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cell_count == CNT_W'(1) |-> at_first && at_last)
      else $error("single cell list not at both ends");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != STS_OK |-> read_value == '0)
      else $error("read data on a failed command");

endmodule

bind cursor_doubly_linked_list_unit cdll_checker #(.CAPACITY(CAPACITY)) u_cdll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
